// File: rtl/tqm_pkg.sv
// Shared types, constants and quadrature rule tables for the triangle quadrature mapper.
`default_nettype none

package tqm_pkg;

  localparam int COORD_W  = 32;
  localparam int WFRAC    = 30;
  localparam int WT_W     = 64;
  localparam int ORDER_W  = 3;
  localparam int PT_W     = 3;
  localparam int TIDX_W   = 5;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int CHUNK_W  = 16;
  localparam int CHUNK_CW = 3;
  localparam int OPA_W    = DIFF_W + 1;
  localparam int OPB_W    = 5 * CHUNK_W + 1;
  localparam int PROD_W   = OPA_W + CHUNK_W + 1;
  localparam int ACC_W    = 100;
  localparam int RND_W    = ACC_W - WFRAC;

  // last chunk index per product: 33-bit, 32-bit and 81-bit multiplicands
  localparam logic [CHUNK_CW-1:0] DET_LAST = 3'd2;
  localparam logic [CHUNK_CW-1:0] MAP_LAST = 3'd1;
  localparam logic [CHUNK_CW-1:0] WT_LAST  = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex0_x;
    logic signed [COORD_W-1:0] vertex0_y;
    logic signed [COORD_W-1:0] vertex1_x;
    logic signed [COORD_W-1:0] vertex1_y;
    logic signed [COORD_W-1:0] vertex2_x;
    logic signed [COORD_W-1:0] vertex2_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mapped_x;
    logic signed [COORD_W-1:0] mapped_y;
    logic signed [WT_W-1:0]    scaled_weight;
    logic [PT_W-1:0]           point_number;
    logic                      final_point;
  } out_item_t;

  typedef struct packed {
    logic                issue;
    logic                clear;
    logic                last;
    logic                sub;
    logic [CHUNK_CW-1:0] chunk;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [31:0] xi;
    logic signed [31:0] eta;
    logic signed [31:0] wt;
  } rule_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DET_A,
    S_DET_B,
    S_DET_WAIT,
    S_DET_SAVE,
    S_MAP_A,
    S_MAP_B,
    S_MAP_WAIT,
    S_MAP_RND,
    S_MAP_SAT,
    S_WT_MUL,
    S_WT_WAIT,
    S_WT_RND,
    S_EMIT
  } state_t;

  // Q2.30 reference points and weights, all rules back to back
  function automatic rule_t rule_pt(input logic [TIDX_W-1:0] idx);
    rule_t r;
    case (idx)
      5'd0:  r = '{32'sd357913941, 32'sd357913941, 32'sd536870912};
      5'd1:  r = '{32'sd178956971, 32'sd178956971, 32'sd357913941};
      5'd2:  r = '{32'sd715827883, 32'sd178956971, 32'sd357913941};
      5'd3:  r = '{32'sd178956971, 32'sd715827883, 32'sd357913941};
      5'd4:  r = '{32'sd357913941, 32'sd357913941, -32'sd603979776};
      5'd5:  r = '{32'sd214748365, 32'sd644245094, 32'sd559240533};
      5'd6:  r = '{32'sd214748365, 32'sd214748365, 32'sd559240533};
      5'd7:  r = '{32'sd644245094, 32'sd214748365, 32'sd559240533};
      5'd8:  r = '{32'sd478833546, 32'sd478833546, 32'sd239854156};
      5'd9:  r = '{32'sd478833546, 32'sd116074732, 32'sd239854156};
      5'd10: r = '{32'sd116074732, 32'sd478833546, 32'sd239854156};
      5'd11: r = '{32'sd98329211,  32'sd98329211,  32'sd118059786};
      5'd12: r = '{32'sd98329211,  32'sd877083403, 32'sd118059786};
      5'd13: r = '{32'sd877083403, 32'sd98329211,  32'sd118059786};
      5'd14: r = '{32'sd357913941, 32'sd357913941, 32'sd241591910};
      5'd15: r = '{32'sd504811197, 32'sd504811197, 32'sd142157139};
      5'd16: r = '{32'sd504811197, 32'sd64119429,  32'sd142157139};
      5'd17: r = '{32'sd64119429,  32'sd504811197, 32'sd142157139};
      5'd18: r = '{32'sd108755559, 32'sd108755559, 32'sd135226165};
      5'd19: r = '{32'sd108755559, 32'sd856230706, 32'sd135226165};
      5'd20: r = '{32'sd856230706, 32'sd108755559, 32'sd135226165};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [TIDX_W-1:0] rule_first(input logic [ORDER_W-1:0] order);
    logic [TIDX_W-1:0] f;
    case (order)
      3'd2:    f = 5'd1;
      3'd3:    f = 5'd4;
      3'd4:    f = 5'd8;
      3'd5:    f = 5'd14;
      default: f = 5'd0;
    endcase
    return f;
  endfunction

  function automatic logic [PT_W-1:0] rule_count(input logic [ORDER_W-1:0] order);
    logic [PT_W-1:0] n;
    case (order)
      3'd1:    n = 3'd1;
      3'd2:    n = 3'd3;
      3'd3:    n = 3'd4;
      3'd4:    n = 3'd6;
      3'd5:    n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tqm_mac.sv
// Shared chunked multiply-accumulate unit: 34x17 signed multiplier and shifted accumulator.
`default_nettype none

module tqm_mac (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tqm_pkg::mac_ctl_t                   ctl,
  input  wire logic signed [tqm_pkg::OPA_W-1:0]    op_a,
  input  wire logic signed [tqm_pkg::OPB_W-1:0]    op_b,
  output logic signed [tqm_pkg::ACC_W-1:0]         acc
);

  localparam int CHUNK_W = tqm_pkg::CHUNK_W;
  localparam int PROD_W  = tqm_pkg::PROD_W;
  localparam int ACC_W   = tqm_pkg::ACC_W;

  logic [CHUNK_W:0]                     seg;
  logic signed [CHUNK_W:0]              b_sel;
  logic signed [PROD_W-1:0]             prod;
  logic signed [PROD_W-1:0]             p_r;
  logic [tqm_pkg::CHUNK_CW-1:0]         sh_r;
  logic                                 sub_r;
  logic                                 pv_r;
  logic signed [ACC_W-1:0]              addend;
  logic signed [ACC_W-1:0]              acc_r;

  always_comb begin
    case (ctl.chunk)
      3'd0:    seg = op_b[0*CHUNK_W +: CHUNK_W+1];
      3'd1:    seg = op_b[1*CHUNK_W +: CHUNK_W+1];
      3'd2:    seg = op_b[2*CHUNK_W +: CHUNK_W+1];
      3'd3:    seg = op_b[3*CHUNK_W +: CHUNK_W+1];
      3'd4:    seg = op_b[4*CHUNK_W +: CHUNK_W+1];
      default: seg = '0;
    endcase
  end

  // lower chunks are unsigned digits, the top chunk carries the sign
  assign b_sel = ctl.last ? $signed(seg) : $signed({1'b0, seg[CHUNK_W-1:0]});
  assign prod  = op_a * b_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= prod;
    sh_r  <= ctl.chunk;
    sub_r <= ctl.sub;
  end

  assign addend = ACC_W'(p_r) <<< (CHUNK_W * sh_r);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= sub_r ? acc_r - addend : acc_r + addend;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// File: rtl/triangle_quadrature_mapper_core.sv
// Top level of the triangle quadrature mapper: sequencer, rounding and result register.
//
// Input channel (in_valid, in_stall, in_data): one transaction is one triangle,
// three vertices in signed Q16.16. in_stall is high while a triangle is in work.
// Output channel (out_valid, out_stall, out_data): one transaction per quadrature
// point, point_number counting up from 0 and final_point marking the last one.
// Configuration: cfg_wr_en with cfg_wr_data writes quad_order (reset 1). Orders
// 1..5 give 1, 3, 4, 6 and 7 points; 0, 6 and 7 give none and free the input at once.
// Datapath: all products go through one 34x17 multiplier in 16-bit chunks.
// The determinant comes first, then for each point the two mapped coordinates
// and then the weight; a triangle holds the input until its last point is loaded
// into the result register.
// The result register keeps one point; while out_stall holds it, the sequencer
// waits before loading the next point. The last point may still wait there while
// the next triangle is accepted.
// Reset (rst_n low, synchronous) returns to idle, drops out_valid and sets order 1.
`default_nettype none

module triangle_quadrature_mapper_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tqm_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tqm_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [tqm_pkg::ORDER_W-1:0]       cfg_wr_data
);

  localparam int COORD_W = tqm_pkg::COORD_W;
  localparam int DIFF_W  = tqm_pkg::DIFF_W;
  localparam int OPA_W   = tqm_pkg::OPA_W;
  localparam int OPB_W   = tqm_pkg::OPB_W;
  localparam int ACC_W   = tqm_pkg::ACC_W;
  localparam int RND_W   = tqm_pkg::RND_W;
  localparam int WFRAC   = tqm_pkg::WFRAC;
  localparam int WT_W    = tqm_pkg::WT_W;
  localparam int SUM_W   = RND_W + 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (WFRAC - 1);

  tqm_pkg::state_t                  state_r, state_nxt;
  logic [tqm_pkg::ORDER_W-1:0]      ord_r;
  logic [tqm_pkg::PT_W-1:0]         cnt_r;
  logic [tqm_pkg::TIDX_W-1:0]       first_r;
  logic [tqm_pkg::PT_W-1:0]         idx_r;
  logic [tqm_pkg::CHUNK_CW-1:0]     chunk_r;
  logic                             axis_r;
  logic signed [COORD_W-1:0]        x0_r, y0_r, mx_r, my_r;
  logic signed [DIFF_W-1:0]         d1x_r, d1y_r, d2x_r, d2y_r;
  logic signed [OPB_W-1:0]          det_r;
  tqm_pkg::rule_t                   row_r;
  logic signed [RND_W-1:0]          rnd_r;
  logic                             out_valid_r;
  tqm_pkg::out_item_t               out_data_r;

  tqm_pkg::mac_ctl_t                ctl;
  logic signed [OPA_W-1:0]          op_a;
  logic signed [OPB_W-1:0]          op_b;
  logic signed [ACC_W-1:0]          acc;
  logic                             chunk_last;
  logic                             in_take;
  logic                             out_free;
  logic                             last_pt;
  logic [tqm_pkg::PT_W-1:0]         new_cnt;
  logic signed [ACC_W-1:0]          rnd_sum;
  logic signed [SUM_W-1:0]          map_sum;
  logic signed [COORD_W-1:0]        map_sat;
  logic signed [WT_W-1:0]           wt_sat;

  assign in_take  = (state_r == tqm_pkg::S_IDLE) && in_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign last_pt  = (idx_r == cnt_r - 3'd1);
  assign new_cnt  = tqm_pkg::rule_count(ord_r);

  tqm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tqm_pkg::S_IDLE:     if (in_valid && new_cnt != '0) state_nxt = tqm_pkg::S_DET_A;
      tqm_pkg::S_DET_A:    if (chunk_last) state_nxt = tqm_pkg::S_DET_B;
      tqm_pkg::S_DET_B:    if (chunk_last) state_nxt = tqm_pkg::S_DET_WAIT;
      tqm_pkg::S_DET_WAIT: state_nxt = tqm_pkg::S_DET_SAVE;
      tqm_pkg::S_DET_SAVE: state_nxt = tqm_pkg::S_MAP_A;
      tqm_pkg::S_MAP_A:    if (chunk_last) state_nxt = tqm_pkg::S_MAP_B;
      tqm_pkg::S_MAP_B:    if (chunk_last) state_nxt = tqm_pkg::S_MAP_WAIT;
      tqm_pkg::S_MAP_WAIT: state_nxt = tqm_pkg::S_MAP_RND;
      tqm_pkg::S_MAP_RND:  state_nxt = tqm_pkg::S_MAP_SAT;
      tqm_pkg::S_MAP_SAT:  state_nxt = axis_r ? tqm_pkg::S_WT_MUL : tqm_pkg::S_MAP_A;
      tqm_pkg::S_WT_MUL:   if (chunk_last) state_nxt = tqm_pkg::S_WT_WAIT;
      tqm_pkg::S_WT_WAIT:  state_nxt = tqm_pkg::S_WT_RND;
      tqm_pkg::S_WT_RND:   state_nxt = tqm_pkg::S_EMIT;
      tqm_pkg::S_EMIT: begin
        if (out_free) state_nxt = last_pt ? tqm_pkg::S_IDLE : tqm_pkg::S_MAP_A;
      end
      default:             state_nxt = tqm_pkg::S_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    ctl        = '0;
    ctl.chunk  = chunk_r;
    op_a       = '0;
    op_b       = '0;
    chunk_last = 1'b0;
    case (state_r)
      tqm_pkg::S_DET_A: begin
        chunk_last = (chunk_r == tqm_pkg::DET_LAST);
        ctl.issue  = 1'b1;
        op_a       = OPA_W'(d1x_r);
        op_b       = OPB_W'(d2y_r);
      end
      tqm_pkg::S_DET_B: begin
        chunk_last = (chunk_r == tqm_pkg::DET_LAST);
        ctl.issue  = 1'b1;
        ctl.sub    = 1'b1;
        op_a       = OPA_W'(d2x_r);
        op_b       = OPB_W'(d1y_r);
      end
      tqm_pkg::S_MAP_A: begin
        chunk_last = (chunk_r == tqm_pkg::MAP_LAST);
        ctl.issue  = 1'b1;
        op_a       = axis_r ? OPA_W'(d1y_r) : OPA_W'(d1x_r);
        op_b       = OPB_W'(row_r.xi);
      end
      tqm_pkg::S_MAP_B: begin
        chunk_last = (chunk_r == tqm_pkg::MAP_LAST);
        ctl.issue  = 1'b1;
        op_a       = axis_r ? OPA_W'(d2y_r) : OPA_W'(d2x_r);
        op_b       = OPB_W'(row_r.eta);
      end
      tqm_pkg::S_WT_MUL: begin
        chunk_last = (chunk_r == tqm_pkg::WT_LAST);
        ctl.issue  = 1'b1;
        op_a       = OPA_W'(row_r.wt);
        op_b       = det_r;
      end
      tqm_pkg::S_IDLE, tqm_pkg::S_DET_SAVE, tqm_pkg::S_MAP_RND, tqm_pkg::S_WT_RND: begin
        ctl.clear  = 1'b1;
      end
      default: begin
        ctl.clear  = 1'b0;
      end
    endcase
    ctl.last = chunk_last;
  end

  // round half away from zero by WFRAC bits
  assign rnd_sum = acc + (acc[ACC_W-1] ? HALF - ACC_W'(1) : HALF);

  assign map_sum = SUM_W'(rnd_r) + SUM_W'(axis_r ? y0_r : x0_r);

  always_comb begin
    if ((map_sum[SUM_W-1:COORD_W-1] == '0) || (map_sum[SUM_W-1:COORD_W-1] == '1)) begin
      map_sat = map_sum[COORD_W-1:0];
    end else begin
      map_sat = map_sum[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_comb begin
    if ((rnd_r[RND_W-1:WT_W-1] == '0) || (rnd_r[RND_W-1:WT_W-1] == '1)) begin
      wt_sat = rnd_r[WT_W-1:0];
    end else begin
      wt_sat = rnd_r[RND_W-1] ? {1'b1, {(WT_W-1){1'b0}}} : {1'b0, {(WT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tqm_pkg::S_IDLE;
      ord_r       <= 3'd1;
      out_valid_r <= 1'b0;
      chunk_r     <= '0;
      idx_r       <= '0;
      axis_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        ord_r <= cfg_wr_data;
      end
      if (ctl.issue) begin
        chunk_r <= chunk_last ? '0 : chunk_r + 3'd1;
      end
      if (in_take) begin
        idx_r  <= '0;
        axis_r <= 1'b0;
      end else if (state_r == tqm_pkg::S_MAP_SAT) begin
        axis_r <= 1'b1;
      end else if (state_r == tqm_pkg::S_EMIT && out_free) begin
        idx_r  <= idx_r + 3'd1;
        axis_r <= 1'b0;
      end
      if (state_r == tqm_pkg::S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cnt_r   <= new_cnt;
      first_r <= tqm_pkg::rule_first(ord_r);
      x0_r    <= in_data.vertex0_x;
      y0_r    <= in_data.vertex0_y;
      d1x_r   <= DIFF_W'(in_data.vertex1_x) - DIFF_W'(in_data.vertex0_x);
      d1y_r   <= DIFF_W'(in_data.vertex1_y) - DIFF_W'(in_data.vertex0_y);
      d2x_r   <= DIFF_W'(in_data.vertex2_x) - DIFF_W'(in_data.vertex0_x);
      d2y_r   <= DIFF_W'(in_data.vertex2_y) - DIFF_W'(in_data.vertex0_y);
    end
    if (state_r == tqm_pkg::S_DET_SAVE) begin
      det_r <= acc[OPB_W-1:0];
      row_r <= tqm_pkg::rule_pt(first_r);
    end
    if (state_r == tqm_pkg::S_EMIT && out_free) begin
      row_r <= tqm_pkg::rule_pt(first_r + tqm_pkg::TIDX_W'(idx_r) + 5'd1);
    end
    if (state_r == tqm_pkg::S_MAP_RND || state_r == tqm_pkg::S_WT_RND) begin
      rnd_r <= rnd_sum[ACC_W-1:WFRAC];
    end
    if (state_r == tqm_pkg::S_MAP_SAT) begin
      if (axis_r) begin
        my_r <= map_sat;
      end else begin
        mx_r <= map_sat;
      end
    end
    if (state_r == tqm_pkg::S_EMIT && out_free) begin
      out_data_r.mapped_x      <= mx_r;
      out_data_r.mapped_y      <= my_r;
      out_data_r.scaled_weight <= wt_sat;
      out_data_r.point_number  <= idx_r;
      out_data_r.final_point   <= last_pt;
    end
  end

  assign in_stall  = (state_r != tqm_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
